### hdl/gle_pkg.sv
// Shared types and constants for the gray Laplacian edge filter.
// Beat structs for both channels, stage control, register indexes.
// No dependencies.
package gle_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 13;

  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd4096;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd2160;
  localparam logic [CFG_W-1:0] DIM_MIN      = 13'd3;

  localparam logic [9:0] GRAY_RECIP = 10'd683;
  localparam int         GRAY_SHIFT = 11;

  localparam logic       REQ_PIXEL = 1'b0;
  localparam logic       REQ_PAD   = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             frame_last;
  } out_beat_t;

  typedef struct packed {
    logic shift;
    logic emit;
    logic border;
    logic last;
  } stage_ctl_t;

  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(r) + 10'(g) + 10'(b);
    prod = 20'(sum) * 20'(GRAY_RECIP);
    return prod[GRAY_SHIFT +: PIX_W];
  endfunction

endpackage

### hdl/gle_line_mem.sv
// Line memory: one word per column holding the two previous gray rows.
// Synchronous single-port write, single-port read with registered data.
// No dependencies.
module gle_line_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/gle_kernel.sv
// 3x3 window, Laplacian kernel, clamp and output register.
// Depends on gle_pkg for beat and stage control types.
module gle_kernel
  import gle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  stage_ctl_t       ctl,
  input  logic [PIX_W-1:0] top,
  input  logic [PIX_W-1:0] mid,
  input  logic [PIX_W-1:0] gray,
  output logic             ready,
  output logic             result_valid,
  input  logic             result_stall,
  output out_beat_t        result
);

  logic [PIX_W-1:0] win [3][3];
  logic             s2_valid;
  stage_ctl_t       s2_ctl;
  logic             s2_move;
  logic [10:0]      nsum;
  logic [10:0]      center8;
  logic [10:0]      diff;
  logic [PIX_W-1:0] lap;

  assign s2_move = s2_valid && (!result_valid || !result_stall);
  assign ready   = !s2_valid || s2_move;

  always_comb begin
    nsum = 11'(win[0][0]) + 11'(win[0][1]) + 11'(win[0][2])
         + 11'(win[1][0]) + 11'(win[1][2])
         + 11'(win[2][0]) + 11'(win[2][1]) + 11'(win[2][2]);
    center8 = {win[1][1], 3'b000};
    diff = center8 - nsum;
    if (nsum > center8) begin
      lap = '0;
    end else if (diff[10:8] != 3'b000) begin
      lap = '1;
    end else begin
      lap = diff[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load && ctl.shift) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= top;
      win[1][2] <= mid;
      win[2][2] <= gray;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (load) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_ctl <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_move && s2_ctl.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && s2_ctl.emit) begin
      result.edge_value <= s2_ctl.border ? '0 : lap;
      result.frame_last <= s2_ctl.last;
    end
  end

endmodule

### hdl/gray_laplacian_edge_filter_core.sv
// Gray Laplacian edge filter: a beat passes stage 1, the window stage and the output register.
// Throughput is one beat per cycle when not stalled, set by one read and one write of the line
// memory per cycle. Frame size product is registered: input stalls while settle is set after
// reset and after each register write. Reset zeroes the counters, sets width 4096 and height
// 2160; line memory and window are not cleared (stale data only reaches border results).
module gray_laplacian_edge_filter_core
  import gle_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  in_beat_t         pixel,
  output logic             result_valid,
  input  logic             result_stall,
  output out_beat_t        result
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int OPW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int FSW = 2 * CFG_W;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
    logic [CFG_W-1:0] r;
    if (v < DIM_MIN) begin
      r = DIM_MIN;
    end else if (32'(v) > hi) begin
      r = CFG_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [FSW-1:0]   frame_size_m1;
  logic             settle;

  logic [CW-1:0]    in_column;
  logic [RW-1:0]    in_row;
  logic [OPW-1:0]   out_position;

  logic             accept;
  logic             can_load;
  logic             in_frame;
  logic             is_pad;
  logic             enter;
  stage_ctl_t       ctl_next;
  logic             col_wrap;

  logic             s1_valid;
  stage_ctl_t       s1_ctl;
  logic [PIX_W-1:0] s1_gray;
  logic [CW-1:0]    s1_col;
  logic             s1_move;
  logic             kern_ready;

  logic [2*PIX_W-1:0] rd_data;

  assign s1_move     = s1_valid && kern_ready;
  assign can_load    = !s1_valid || s1_move;
  assign pixel_stall = settle || !can_load;
  assign accept      = pixel_valid && !pixel_stall;

  assign in_frame = 32'(in_row) < 32'(image_height);
  assign is_pad   = pixel.req_type == REQ_PAD;
  assign enter    = accept && !(in_frame && is_pad);
  assign col_wrap = 32'(in_column) + 32'd1 >= 32'(image_width);

  always_comb begin
    if (in_frame) begin
      ctl_next.shift  = 1'b1;
      ctl_next.emit   = (32'(in_row) >= 32'd2) || (in_row == RW'(1) && in_column != '0);
      ctl_next.border = (in_column <= CW'(1)) || (32'(in_row) <= 32'd1);
      ctl_next.last   = 32'(out_position) == 32'(frame_size_m1);
    end else begin
      ctl_next.shift  = 1'b0;
      ctl_next.emit   = 1'b1;
      ctl_next.border = 1'b1;
      ctl_next.last   = 32'(out_position) >= 32'(frame_size_m1);
    end
  end

  always_ff @(posedge clk) begin
    frame_size_m1 <= FSW'(image_width) * FSW'(image_height) - FSW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= clamp_dim(WIDTH_RESET, MAX_WIDTH);
      image_height <= clamp_dim(HEIGHT_RESET, MAX_HEIGHT);
      settle       <= 1'b1;
      in_column    <= '0;
      in_row       <= '0;
      out_position <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= clamp_dim(cfg_data, MAX_WIDTH);
        REG_IMAGE_HEIGHT: image_height <= clamp_dim(cfg_data, MAX_HEIGHT);
        default: ;
      endcase
      settle       <= 1'b1;
      in_column    <= '0;
      in_row       <= '0;
      out_position <= '0;
    end else begin
      settle <= 1'b0;
      if (enter) begin
        if (ctl_next.shift) begin
          if (col_wrap) begin
            in_column <= '0;
            in_row    <= in_row + RW'(1);
          end else begin
            in_column <= in_column + CW'(1);
          end
          if (ctl_next.emit) begin
            out_position <= out_position + OPW'(1);
          end
        end else if (ctl_next.last) begin
          in_column    <= '0;
          in_row       <= '0;
          out_position <= '0;
        end else begin
          out_position <= out_position + OPW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (can_load) begin
      s1_valid <= enter;
    end
  end

  always_ff @(posedge clk) begin
    if (enter) begin
      s1_ctl  <= ctl_next;
      s1_gray <= gray_of(pixel.red, pixel.green, pixel.blue);
      s1_col  <= in_column;
    end
  end

  gle_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (2 * PIX_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (enter),
    .rd_addr (in_column),
    .rd_data (rd_data),
    .wr_en   (s1_move && s1_ctl.shift),
    .wr_addr (s1_col),
    .wr_data ({rd_data[PIX_W-1:0], s1_gray})
  );

  gle_kernel u_kernel (
    .clk          (clk),
    .rst          (rst),
    .load         (s1_move),
    .ctl          (s1_ctl),
    .top          (rd_data[2*PIX_W-1:PIX_W]),
    .mid          (rd_data[PIX_W-1:0]),
    .gray         (s1_gray),
    .ready        (kern_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
